// File: design/meter_reply_frame_parser_unit_defines.svh
// assertion macros for the meter reply frame parser
// used by the top level; needs nothing else
`ifndef METER_REPLY_FRAME_PARSER_UNIT_DEFINES_SVH
`define METER_REPLY_FRAME_PARSER_UNIT_DEFINES_SVH

// same-cycle implication
`define MRFP_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("mrfp assertion failed");

// next-cycle implication
`define MRFP_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("mrfp assertion failed");

`endif

// File: design/mrfp_pkg.sv
// constants, types and weight table of the meter reply frame parser
// no dependencies
`default_nettype none

package mrfp_pkg;

	localparam int MAX_VALUE_BYTES = 4;
	localparam int VIDX_W = (MAX_VALUE_BYTES > 1) ? $clog2(MAX_VALUE_BYTES) : 1;
	localparam int POS_W = 9;
	localparam int SIZE_W = POS_W + 1;
	localparam int MAG_W = 28;
	localparam int ADDR_W = 48;
	localparam int ADDR_BYTES = 6;

	localparam logic [7:0] START_BYTE = 8'h68;
	localparam logic [7:0] CTRL_READ_REPLY = 8'h91;
	localparam logic [7:0] STOP_BYTE = 8'h16;
	localparam logic [7:0] DATA_OFFSET = 8'h33;
	localparam logic [7:0] PREAMBLE_BYTE = 8'hFE;
	localparam logic [7:0] SIGN_CLEAR = 8'h7F;
	localparam logic [ADDR_W-1:0] ANY_ADDRESS = 48'hAAAA_AAAA_AAAA;

	localparam logic [POS_W-1:0] POS_MAX = 9'd511;
	localparam logic [POS_W-1:0] POS_START0 = 9'd0;
	localparam logic [POS_W-1:0] POS_ADDR_FIRST = 9'd1;
	localparam logic [POS_W-1:0] POS_ADDR_LAST = 9'd6;
	localparam logic [POS_W-1:0] POS_START1 = 9'd7;
	localparam logic [POS_W-1:0] POS_CTRL = 9'd8;
	localparam logic [POS_W-1:0] POS_LEN = 9'd9;
	localparam logic [POS_W-1:0] POS_VALUE = 9'd14;

	localparam logic [SIZE_W-1:0] MIN_FRAME = 10'd13;
	localparam logic [SIZE_W-1:0] ID_BYTES = 10'd4;
	localparam logic [SIZE_W-1:0] LEN_TO_SIZE = 10'd10;
	localparam logic [SIZE_W-1:0] LEN_MAX = SIZE_W'(4 + MAX_VALUE_BYTES);

	typedef enum logic [1:0] {
		ST_OK = 2'd0,
		ST_MALFORMED = 2'd1,
		ST_ADDR_MISMATCH = 2'd2,
		ST_LENGTH_ERR = 2'd3
	} status_t;

	typedef logic [MAG_W-1:0] weight_arr_t [MAX_VALUE_BYTES];

	function automatic weight_arr_t calc_weights();
		weight_arr_t w;
		logic [MAG_W-1:0] acc;
		acc = MAG_W'(1);
		for (int i = 0; i < MAX_VALUE_BYTES; i++) begin
			w[i] = acc;
			acc = MAG_W'(acc * MAG_W'(100));
		end
		return w;
	endfunction

	// weight of value byte k is 100**k, modulo the magnitude width
	localparam weight_arr_t DIGIT_WEIGHT = calc_weights();

	typedef struct packed {
		logic in_use;
		logic is_top;
		logic sign;
		logic [MAG_W-1:0] term;
	} value_term_t;

endpackage

`default_nettype wire

// File: design/mrfp_rx_if.sv
// byte input channel of the meter reply frame parser
// no dependencies
`default_nettype none

interface mrfp_rx_if;
	logic valid;
	logic ready;
	logic [7:0] rx_byte;
	logic frame_end;

	modport source (output valid, output rx_byte, output frame_end, input ready);
	modport sink (input valid, input rx_byte, input frame_end, output ready);
endinterface

`default_nettype wire

// File: design/mrfp_result_if.sv
// result channel of the meter reply frame parser
// depends on mrfp_pkg
`default_nettype none

interface mrfp_result_if;
	import mrfp_pkg::*;
	logic valid;
	logic ready;
	logic [1:0] status;
	logic [MAG_W-1:0] value_magnitude;
	logic value_negative;

	modport source (output valid, output status, output value_magnitude,
		output value_negative, input ready);
	modport sink (input valid, input status, input value_magnitude,
		input value_negative, output ready);
endinterface

`default_nettype wire

// File: design/mrfp_value_term.sv
// weighted binary term of one value byte: offset removal, sign strip, bcd pair
// depends on mrfp_pkg
`default_nettype none

module mrfp_value_term (
	input  logic [7:0]                 rx_byte,
	input  logic [mrfp_pkg::POS_W-1:0] pos,
	input  logic [7:0]                 length_byte,
	output mrfp_pkg::value_term_t      vt
);
	import mrfp_pkg::*;

	logic [7:0] v;
	logic [7:0] vc;
	logic [7:0] pair;
	logic [POS_W-1:0] k;
	logic [SIZE_W-1:0] k_ext;
	logic [SIZE_W-1:0] len_ext;
	logic in_slot;

	always_comb begin
		v = rx_byte - DATA_OFFSET;
		k = pos - POS_VALUE;
		k_ext = {1'b0, k} + ID_BYTES;
		len_ext = {2'b00, length_byte};
		in_slot = (pos >= POS_VALUE) && (k < POS_W'(MAX_VALUE_BYTES));
		vt.in_use = in_slot && (k_ext < len_ext);
		vt.is_top = in_slot && ((k_ext + SIZE_W'(1)) == len_ext);
		vt.sign = v[7];
		vc = vt.is_top ? (v & SIGN_CLEAR) : v;
		pair = ({4'b0000, vc[7:4]} * 8'd10) + {4'b0000, vc[3:0]};
		vt.term = vt.in_use
			? MAG_W'({(MAG_W-8)'(0), pair} * DIGIT_WEIGHT[k[VIDX_W-1:0]])
			: '0;
	end

endmodule

`default_nettype wire

// File: design/meter_reply_frame_parser_unit.sv
// top level of the meter reply frame parser: input stage, frame state, result register
// depends on mrfp_pkg, mrfp_rx_if, mrfp_result_if, mrfp_value_term and the defines header
//
// channel  dir  handshake      payload
// rx       in   valid/ready    rx_byte[7:0], frame_end
// result   out  valid/ready    status[1:0], value_magnitude[27:0], value_negative
// cfg      in   cfg_wr_en      cfg_wr_data[47:0] (meter address)
//
// one byte per cycle sustained while rx is not stalled; a byte is registered in the input
// stage and then updates the frame state; a frame-end byte also loads the result register
// the value is accumulated as each value byte arrives, one multiply per byte
// arst_n clears the frame state and sets the address to the wildcard
// rx stalls only while a frame-end byte waits behind a full, stalled result register
`default_nettype none
`include "meter_reply_frame_parser_unit_defines.svh"

module meter_reply_frame_parser_unit (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_wr_en,
	input  logic [mrfp_pkg::ADDR_W-1:0] cfg_wr_data,
	mrfp_rx_if.sink                     rx,
	mrfp_result_if.source               result
);
	import mrfp_pkg::*;

	logic valid_s1;
	logic [7:0] rx_byte_s1;
	logic frame_end_s1;

	logic [ADDR_W-1:0] address_q;
	logic [POS_W-1:0] pos_q;
	logic in_preamble_q;
	logic header_bad_q;
	logic address_bad_q;
	logic [7:0] length_q;
	logic [MAG_W-1:0] acc_q;
	logic neg_q;

	logic out_valid_q;
	status_t out_status_q;
	logic [MAG_W-1:0] out_mag_q;
	logic out_neg_q;

	logic stall;
	logic advance;
	logic is_pre;
	logic take;
	logic [SIZE_W-1:0] size;
	logic [SIZE_W-1:0] len_ext;
	logic [2:0] addr_idx;
	logic [7:0] addr_byte;
	logic [POS_W-1:0] pos_n;
	logic header_bad_n;
	logic address_bad_n;
	logic [7:0] length_n;
	logic [MAG_W-1:0] acc_n;
	logic neg_n;
	status_t status_n;
	value_term_t vt;

	assign stall = valid_s1 && frame_end_s1 && out_valid_q && !result.ready;
	assign advance = valid_s1 && !stall;
	assign rx.ready = !stall;

	mrfp_value_term u_value_term (
		.rx_byte     (rx_byte_s1),
		.pos         (pos_q),
		.length_byte (length_q),
		.vt          (vt)
	);

	always_comb begin
		is_pre = in_preamble_q && (rx_byte_s1 == PREAMBLE_BYTE);
		take = !is_pre;
		size = take ? ({1'b0, pos_q} + SIZE_W'(1)) : '0;
		addr_idx = 3'(pos_q - POS_ADDR_FIRST);
		addr_byte = address_q[8*addr_idx +: 8];

		header_bad_n = header_bad_q;
		address_bad_n = address_bad_q;
		length_n = length_q;
		acc_n = acc_q;
		neg_n = neg_q;
		pos_n = pos_q;
		if (take) begin
			if ((pos_q == POS_START0 || pos_q == POS_START1) && rx_byte_s1 != START_BYTE) begin
				header_bad_n = 1'b1;
			end
			if (pos_q == POS_CTRL && rx_byte_s1 != CTRL_READ_REPLY) begin
				header_bad_n = 1'b1;
			end
			if (pos_q >= POS_ADDR_FIRST && pos_q <= POS_ADDR_LAST &&
				address_q != ANY_ADDRESS && rx_byte_s1 != addr_byte) begin
				address_bad_n = 1'b1;
			end
			if (pos_q == POS_LEN) begin
				length_n = rx_byte_s1;
			end
			acc_n = acc_q + vt.term;
			if (vt.is_top) begin
				neg_n = vt.sign;
			end
			if (pos_q != POS_MAX) begin
				pos_n = pos_q + POS_W'(1);
			end
		end

		len_ext = {2'b00, length_n};
		if (size < MIN_FRAME || header_bad_n || rx_byte_s1 != STOP_BYTE) begin
			status_n = ST_MALFORMED;
		end else if (address_bad_n) begin
			status_n = ST_ADDR_MISMATCH;
		end else if (len_ext <= ID_BYTES || len_ext > LEN_MAX ||
			(len_ext + LEN_TO_SIZE) >= size) begin
			status_n = ST_LENGTH_ERR;
		end else begin
			status_n = ST_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx.ready) begin
			valid_s1 <= rx.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.valid && rx.ready) begin
			rx_byte_s1 <= rx.rx_byte;
			frame_end_s1 <= rx.frame_end;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			address_q <= ANY_ADDRESS;
		end else if (cfg_wr_en) begin
			address_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			in_preamble_q <= 1'b1;
			header_bad_q <= 1'b0;
			address_bad_q <= 1'b0;
			length_q <= '0;
			acc_q <= '0;
			neg_q <= 1'b0;
		end else if (advance) begin
			if (frame_end_s1) begin
				pos_q <= '0;
				in_preamble_q <= 1'b1;
				header_bad_q <= 1'b0;
				address_bad_q <= 1'b0;
				length_q <= '0;
				acc_q <= '0;
				neg_q <= 1'b0;
			end else begin
				pos_q <= pos_n;
				in_preamble_q <= is_pre;
				header_bad_q <= header_bad_n;
				address_bad_q <= address_bad_n;
				length_q <= length_n;
				acc_q <= acc_n;
				neg_q <= neg_n;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && frame_end_s1) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && frame_end_s1) begin
			out_status_q <= status_n;
			out_mag_q <= (status_n == ST_OK) ? acc_n : '0;
			out_neg_q <= (status_n == ST_OK) ? neg_n : 1'b0;
		end
	end

	assign result.valid = out_valid_q;
	assign result.status = out_status_q;
	assign result.value_magnitude = out_mag_q;
	assign result.value_negative = out_neg_q;

	`MRFP_ASSERT_NXT(a_result_after_end, clk, arst_n, advance && frame_end_s1, out_valid_q)
	`MRFP_ASSERT_IMP(a_zero_on_error, clk, arst_n, out_valid_q && out_status_q != ST_OK, out_mag_q == '0 && !out_neg_q)
	`MRFP_ASSERT_IMP(a_preamble_clean, clk, arst_n, in_preamble_q, pos_q == '0 && !header_bad_q && !address_bad_q)
	`MRFP_ASSERT_IMP(a_stall_cause, clk, arst_n, !rx.ready, valid_s1 && frame_end_s1 && out_valid_q)

endmodule

`default_nettype wire
